// File: sv/fcfl_pkg.sv
// Shared widths, operation codes and result codes of the chunk allocator.
package fcfl_pkg;

  localparam int ADDR_W     = 12;
  localparam int LINK_W     = ADDR_W + 1;
  localparam int LINK_DEPTH = 1 << ADDR_W;
  localparam int CHUNK_W    = 11;
  localparam int BIN_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BIN_W;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_UNITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_UNITS   = 1'b1;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OOM       = 2'd1,
    STS_BIN_SMALL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_LIST  = 2'd0,
    SRC_SPLIT = 2'd1,
    SRC_WHOLE = 2'd2,
    SRC_BIN   = 2'd3
  } source_t;

endpackage

// File: sv/fcfl_if.sv
// Request and result channel interfaces of the chunk allocator.
interface fcfl_req_if;
  import fcfl_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] chunk_addr;

  modport source (output valid, op, chunk_addr, input ready);
  modport sink   (input valid, op, chunk_addr, output ready);
endinterface

interface fcfl_res_if;
  import fcfl_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr_out;
  logic [1:0]        status;
  logic [1:0]        src;

  modport source (output valid, addr_out, status, src, input ready);
  modport sink   (input valid, addr_out, status, src, output ready);
endinterface

// File: sv/fcfl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fcfl_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fixed_chunk_free_list_allocator.sv
// Chunk allocator: LIFO free list in a link RAM, wilderness carving and bin bump.
// A free, a carve or an error answers in the cycle after the request is taken; a pop
// answers from ST_POP, as the new head comes from a registered link RAM read, and
// takes no new request until then. Throughput: one free or carve per cycle unless out_res stalls.
// Reset (synchronous, rst_n low) empties the list and the wilderness, rewinds the
// bin pointer and restores chunk_units 4 and bin_units 1024; the link RAM is not cleared.
module fixed_chunk_free_list_allocator #(
  parameter int POOL_UNITS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  fcfl_req_if.sink                           in_req,
  fcfl_res_if.source                         out_res,
  input  logic                               cfg_we,
  input  logic [fcfl_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fcfl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import fcfl_pkg::*;

  localparam int NB_W = $clog2(POOL_UNITS + 1);
  localparam int SUM_W = ((NB_W > BIN_W) ? NB_W : BIN_W) + 1;

  typedef enum logic {ST_IDLE, ST_POP} state_t;

  state_t              state_r, state_nxt;
  logic [CHUNK_W-1:0]  chunk_units_r, chunk_units_nxt;
  logic [BIN_W-1:0]    bin_units_r, bin_units_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [ADDR_W-1:0]   head_addr_r, head_addr_nxt;
  logic [ADDR_W-1:0]   wild_base_r, wild_base_nxt;
  logic [BIN_W-1:0]    wild_size_r, wild_size_nxt;
  logic [NB_W-1:0]     next_bin_r, next_bin_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_status_r, out_status_nxt;
  source_t             out_source_r, out_source_nxt;

  logic                in_fire;
  logic                out_free;
  logic                is_pop;
  logic [LINK_W-1:0]   link_rdata;

  logic [BIN_W-1:0]    cu;
  logic [BIN_W-1:0]    bu;
  logic                wild_split;
  logic                wild_whole;
  logic [BIN_W-1:0]    wild_rem;
  logic                bin_small;
  logic [SUM_W-1:0]    nbb_ext;
  logic [SUM_W-1:0]    bin_end;
  logic                pool_oom;
  logic [BIN_W-1:0]    bin_rem;

  assign out_free     = !out_valid_r || out_res.ready;
  assign in_req.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire      = in_req.valid && in_req.ready;
  assign is_pop       = (in_req.op == OP_ALLOC) && head_valid_r;

  // Pushing writes the old head as the link of the freed chunk; popping reads
  // the link of the head chunk. Only one of the two happens per request.
  fcfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (in_fire && (in_req.op == OP_FREE)),
    .waddr (in_req.chunk_addr),
    .wdata ({head_valid_r, head_addr_r}),
    .re    (in_fire && is_pop),
    .raddr (head_addr_r),
    .rdata (link_rdata)
  );

  // A register value of zero behaves as one.
  assign cu = (chunk_units_r == '0) ? BIN_W'(1) : {{(BIN_W-CHUNK_W){1'b0}}, chunk_units_r};
  assign bu = (bin_units_r == '0) ? BIN_W'(1) : bin_units_r;

  assign wild_split = wild_size_r > cu;
  assign wild_whole = wild_size_r == cu;
  assign wild_rem   = wild_size_r - cu;
  assign bin_small  = bu < cu;
  assign nbb_ext    = SUM_W'(next_bin_r);
  assign bin_end    = nbb_ext + SUM_W'(bu);
  assign pool_oom   = bin_end > SUM_W'(POOL_UNITS);
  assign bin_rem    = bu - cu;

  always_comb begin
    state_nxt       = state_r;
    chunk_units_nxt = chunk_units_r;
    bin_units_nxt   = bin_units_r;
    head_valid_nxt  = head_valid_r;
    head_addr_nxt   = head_addr_r;
    wild_base_nxt   = wild_base_r;
    wild_size_nxt   = wild_size_r;
    next_bin_nxt    = next_bin_r;
    out_valid_nxt   = out_valid_r && !out_res.ready;
    out_addr_nxt    = out_addr_r;
    out_status_nxt  = out_status_r;
    out_source_nxt  = out_source_r;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_CHUNK_UNITS: chunk_units_nxt = cfg_wdata[CHUNK_W-1:0];
        CFG_BIN_UNITS:   bin_units_nxt   = cfg_wdata[BIN_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req.op == OP_FREE) begin
            head_valid_nxt = 1'b1;
            head_addr_nxt  = in_req.chunk_addr;
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = in_req.chunk_addr;
            out_status_nxt = STS_OK;
            out_source_nxt = SRC_LIST;
          end else if (is_pop) begin
            state_nxt = ST_POP;
          end else begin
            out_valid_nxt = 1'b1;
            if (wild_split) begin
              wild_size_nxt  = wild_rem;
              out_addr_nxt   = wild_base_r + wild_rem[ADDR_W-1:0];
              out_status_nxt = STS_OK;
              out_source_nxt = SRC_SPLIT;
            end else if (wild_whole) begin
              wild_size_nxt  = '0;
              out_addr_nxt   = wild_base_r;
              out_status_nxt = STS_OK;
              out_source_nxt = SRC_WHOLE;
            end else if (bin_small) begin
              out_addr_nxt   = '0;
              out_status_nxt = STS_BIN_SMALL;
              out_source_nxt = SRC_BIN;
            end else if (pool_oom) begin
              out_addr_nxt   = '0;
              out_status_nxt = STS_OOM;
              out_source_nxt = SRC_BIN;
            end else begin
              // Open a new bin; the chunk comes off its top end.
              wild_base_nxt  = nbb_ext[ADDR_W-1:0];
              wild_size_nxt  = bin_rem;
              next_bin_nxt   = bin_end[NB_W-1:0];
              out_addr_nxt   = nbb_ext[ADDR_W-1:0] + bin_rem[ADDR_W-1:0];
              out_status_nxt = STS_OK;
              out_source_nxt = SRC_BIN;
            end
          end
        end
      end
      ST_POP: begin
        // The link RAM output holds until the next read, so waiting is safe.
        if (out_free) begin
          head_valid_nxt = link_rdata[LINK_W-1];
          head_addr_nxt  = link_rdata[ADDR_W-1:0];
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = head_addr_r;
          out_status_nxt = STS_OK;
          out_source_nxt = SRC_LIST;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      chunk_units_r <= CHUNK_W'(4);
      bin_units_r   <= BIN_W'(1024);
      head_valid_r  <= 1'b0;
      wild_base_r   <= '0;
      wild_size_r   <= '0;
      next_bin_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      chunk_units_r <= chunk_units_nxt;
      bin_units_r   <= bin_units_nxt;
      head_valid_r  <= head_valid_nxt;
      wild_base_r   <= wild_base_nxt;
      wild_size_r   <= wild_size_nxt;
      next_bin_r    <= next_bin_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    head_addr_r  <= head_addr_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_source_r <= out_source_nxt;
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.addr_out = out_addr_r;
  assign out_res.status   = out_status_r;
  assign out_res.src      = out_source_r;

endmodule
